[src/assert_macros.svh]
// assertion macros shared by the frame builder modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, switched off while reset is held
`define ATFB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds through reset
`define ATFB_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/atfb_pkg.sv]
// types, constants and pwm tables of the transmit frame builder
`timescale 1ns / 1ps

package atfb_pkg;

  localparam int IDX_W = 6;

  localparam logic [IDX_W-1:0] DRIVE_LAST_IDX = 6'd34;
  localparam logic [IDX_W-1:0] MODE_LAST_IDX  = 6'd29;
  localparam logic [IDX_W-1:0] SUM_FIRST_IDX  = 6'd3;

  localparam logic OP_DRIVE = 1'b0;
  localparam logic OP_MODE  = 1'b1;

  localparam logic [7:0] SOF_BYTE   = 8'h7E;
  localparam logic [7:0] LEN_DRIVE  = 8'h1F;
  localparam logic [7:0] LEN_MODE   = 8'h1A;
  localparam logic [7:0] FRAME_TYPE = 8'h10;
  localparam logic [7:0] FRAME_ID   = 8'h01;
  localparam logic [7:0] NET_HI     = 8'hFF;
  localparam logic [7:0] NET_LO     = 8'hFE;
  localparam logic [7:0] ZERO_BYTE  = 8'h00;
  localparam logic [7:0] ONE_BYTE   = 8'h01;
  localparam logic [7:0] CHK_BASE   = 8'hFF;
  localparam logic [7:0] MAX_INDEX  = 8'd9;

  localparam logic [7:0] CH_A = 8'h41;
  localparam logic [7:0] CH_C = 8'h43;
  localparam logic [7:0] CH_E = 8'h45;
  localparam logic [7:0] CH_F = 8'h46;
  localparam logic [7:0] CH_G = 8'h47;
  localparam logic [7:0] CH_L = 8'h4C;
  localparam logic [7:0] CH_M = 8'h4D;
  localparam logic [7:0] CH_R = 8'h52;
  localparam logic [7:0] CH_S = 8'h53;
  localparam logic [7:0] CH_T = 8'h54;

  typedef struct packed {
    logic       opcode;
    logic [7:0] value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic             load;
    logic             emit;
    logic [IDX_W-1:0] idx;
  } atfb_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic at_end;
  } atfb_sts_t;

  function automatic logic [7:0] left_pwm(input logic [3:0] idx);
    logic [7:0] res;
    unique case (idx)
      4'd0:    res = 8'h00;
      4'd1:    res = 8'h18;
      4'd2:    res = 8'h18;
      4'd3:    res = 8'h18;
      4'd4:    res = 8'h08;
      4'd5:    res = 8'h00;
      4'd6:    res = 8'h10;
      4'd7:    res = 8'h10;
      4'd8:    res = 8'h0c;
      4'd9:    res = 8'h0c;
      default: res = 8'h00;
    endcase
    return res;
  endfunction

  function automatic logic [7:0] right_pwm(input logic [3:0] idx);
    logic [7:0] res;
    unique case (idx)
      4'd0:    res = 8'h00;
      4'd1:    res = 8'h18;
      4'd2:    res = 8'h08;
      4'd3:    res = 8'h00;
      4'd4:    res = 8'h18;
      4'd5:    res = 8'h18;
      4'd6:    res = 8'h0c;
      4'd7:    res = 8'h08;
      4'd8:    res = 8'h0c;
      4'd9:    res = 8'h08;
      default: res = 8'h00;
    endcase
    return res;
  endfunction

endpackage

[src/atfb_ctrl.sv]
// frame sequencer: accepts requests and steps the byte index
`timescale 1ns / 1ps
`include "assert_macros.svh"

module atfb_ctrl
  import atfb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  atfb_sts_t sts_i,
  output atfb_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SEND = 2'b10
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             accept;

  always_comb begin
    busy   = (state_r == ST_SEND) && !sts_i.at_end;
    accept = start && !busy;

    cmd_o.load = accept;
    cmd_o.emit = (state_r == ST_SEND);
    cmd_o.idx  = idx_r;

    state_nxt = state_r;
    idx_nxt   = idx_r;
    if (accept) begin
      // a new request may follow the checksum byte directly
      state_nxt = ST_SEND;
      idx_nxt   = '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          state_nxt = ST_IDLE;
        end
        ST_SEND: begin
          if (sts_i.at_end) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
        default: begin
          state_nxt = ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  `ATFB_ASSERT(a_idx_range, idx_r <= DRIVE_LAST_IDX, "byte index beyond longest frame")
  `ATFB_ASSERT(a_idx_step, (state_r == ST_SEND) && !sts_i.at_end |=> (state_r == ST_SEND) && (idx_r == $past(idx_r) + 1'b1), "byte index did not advance")
  `ATFB_ASSERT(a_busy_send, busy |-> (state_r == ST_SEND), "busy outside a frame")

endmodule

[src/atfb_dp.sv]
// frame datapath: byte selection, checksum and output register
`timescale 1ns / 1ps
`include "assert_macros.svh"

module atfb_dp
  import atfb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  atfb_cmd_t   cmd_i,
  input  in_item_t    in_data_i,
  input  logic [63:0] dest_i,
  output atfb_sts_t   sts_o,
  output logic        out_valid_o,
  output out_item_t   out_data_o
);

  logic       opcode_r, opcode_nxt;
  logic [7:0] value_r, value_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic       valid_r, valid_nxt;
  out_item_t  data_r, data_nxt;
  logic [3:0] pwm_idx;
  logic [7:0] chk;
  logic [7:0] byte_sel;
  logic       drive;

  always_comb begin
    drive   = (opcode_r == OP_DRIVE);
    pwm_idx = (value_r > MAX_INDEX) ? MAX_INDEX[3:0] : value_r[3:0];
    chk     = CHK_BASE - sum_r;
    sts_o.at_end = (cmd_i.idx == (drive ? DRIVE_LAST_IDX : MODE_LAST_IDX));

    case (cmd_i.idx)
      6'd0:  byte_sel = SOF_BYTE;
      6'd1:  byte_sel = ZERO_BYTE;
      6'd2:  byte_sel = drive ? LEN_DRIVE : LEN_MODE;
      6'd3:  byte_sel = FRAME_TYPE;
      6'd4:  byte_sel = FRAME_ID;
      6'd5:  byte_sel = dest_i[63:56];
      6'd6:  byte_sel = dest_i[55:48];
      6'd7:  byte_sel = dest_i[47:40];
      6'd8:  byte_sel = dest_i[39:32];
      6'd9:  byte_sel = dest_i[31:24];
      6'd10: byte_sel = dest_i[23:16];
      6'd11: byte_sel = dest_i[15:8];
      6'd12: byte_sel = dest_i[7:0];
      6'd13: byte_sel = NET_HI;
      6'd14: byte_sel = NET_LO;
      6'd15: byte_sel = ZERO_BYTE;
      6'd16: byte_sel = ZERO_BYTE;
      6'd17: byte_sel = CH_A;
      6'd18: byte_sel = CH_G;
      6'd19: byte_sel = CH_S;
      6'd20: byte_sel = drive ? CH_M : CH_C;
      6'd21: byte_sel = CH_F;
      6'd22: byte_sel = CH_A;
      6'd23: byte_sel = CH_T;
      6'd24: byte_sel = CH_A;
      6'd25: byte_sel = drive ? CH_L : value_r;
      6'd26: byte_sel = drive ? ONE_BYTE : CH_A;
      6'd27: byte_sel = drive ? left_pwm(pwm_idx) : CH_G;
      6'd28: byte_sel = drive ? CH_R : CH_E;
      6'd29: byte_sel = drive ? ONE_BYTE : chk;
      6'd30: byte_sel = right_pwm(pwm_idx);
      6'd31: byte_sel = CH_A;
      6'd32: byte_sel = CH_G;
      6'd33: byte_sel = CH_E;
      6'd34: byte_sel = chk;
      default: byte_sel = ZERO_BYTE;
    endcase

    opcode_nxt = opcode_r;
    value_nxt  = value_r;
    sum_nxt    = sum_r;
    if (cmd_i.load) begin
      opcode_nxt = in_data_i.opcode;
      value_nxt  = in_data_i.value;
      sum_nxt    = '0;
    end else if (cmd_i.emit && (cmd_i.idx >= SUM_FIRST_IDX)) begin
      sum_nxt = sum_r + byte_sel;
    end

    valid_nxt        = cmd_i.emit;
    data_nxt.tx_byte = byte_sel;
    data_nxt.last    = cmd_i.emit && sts_o.at_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    opcode_r <= opcode_nxt;
    value_r  <= value_nxt;
    sum_r    <= sum_nxt;
    data_r   <= data_nxt;
  end

  assign out_valid_o = valid_r;
  assign out_data_o  = data_r;

  `ATFB_ASSERT(a_sum_clear, cmd_i.load |=> (sum_r == '0), "checksum not cleared on new request")
  `ATFB_ASSERT(a_last_valid, valid_r && data_r.last |-> $past(cmd_i.emit), "last byte without a send step")

endmodule

[src/api_transmit_frame_builder.sv]
// top level of the api transmit-request frame builder
`timescale 1ns / 1ps

// Each accepted request (start high while busy is low) produces one complete
// transmit-request frame on out_data, one byte per clock cycle with out_valid
// high, the checksum byte flagged by last. A drive request (opcode 0) gives a
// 35-byte frame, a mode request (opcode 1) a 30-byte frame. The first byte is
// on the outputs once the sequencer has entered its send state and the byte
// has passed the output register. Bytes then follow with no gaps, stepped by
// the single byte counter in the sequencer. Busy falls in the cycle in which
// the checksum byte is selected, so a following request can be taken then and
// frames run back to back. The receiver has no way to hold bytes off; each
// byte is on the outputs for exactly one cycle. The user must write the
// destination address through cfg_we and cfg_wdata while no frame is in
// flight; the block itself does not enforce this.

module api_transmit_frame_builder
  import atfb_pkg::*;
#(
  parameter logic [63:0] DEST_RESET = 64'h0013A200409EAEF7
)
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_data,
  output logic        out_valid,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [63:0] cfg_wdata
);

  // destination address register, most significant byte sent first
  logic [63:0] dest_r, dest_nxt;
  atfb_cmd_t   cmd;
  atfb_sts_t   sts;

  always_comb begin
    dest_nxt = cfg_we ? cfg_wdata : dest_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dest_r <= DEST_RESET;
    end else begin
      dest_r <= dest_nxt;
    end
  end

  // sequencer: owns the request handshake and the byte index
  atfb_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts_i (sts),
    .cmd_o (cmd)
  );

  // datapath: latches the request, picks each byte, keeps the running sum
  atfb_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_i       (cmd),
    .in_data_i   (in_data),
    .dest_i      (dest_r),
    .sts_o       (sts),
    .out_valid_o (out_valid),
    .out_data_o  (out_data)
  );

endmodule
